FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lr_pkg.sv
// ---------------------------------------------------------------------------
// lr_pkg
// Shared constants and types of the line rasterizer.
// ---------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned COLOR_BITS     = 8;
  localparam int unsigned KIND_BITS      = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // Line orientation decided at start.
  typedef struct packed {
    logic steep;
    logic major_neg;
    logic minor_neg;
    logic nonzero;
  } lr_flags_t;

endpackage

FILE: hw/rtl/lr_ifs.sv
// ---------------------------------------------------------------------------
// Line rasterizer channels
// Valid/ready channels for command transactions and pixel transactions.
// ---------------------------------------------------------------------------
interface lr_item_if #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic signed [COORD_BITS-1:0]         start_x;
  logic signed [COORD_BITS-1:0]         start_y;
  logic signed [COORD_BITS-1:0]         end_x;
  logic signed [COORD_BITS-1:0]         end_y;
  logic [lr_pkg::COLOR_BITS-1:0]        color_index;
  logic [lr_pkg::KIND_BITS-1:0]         coord_kind;

  modport source (output valid, op, start_x, start_y, end_x, end_y, color_index, coord_kind,
                  input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, color_index, coord_kind,
                  output ready);
endinterface

interface lr_pixel_if #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic signed [COORD_BITS-1:0]         pixel_x;
  logic signed [COORD_BITS-1:0]         pixel_y;
  logic [lr_pkg::COLOR_BITS-1:0]        pixel_color;
  logic [lr_pkg::KIND_BITS-1:0]         pixel_kind;
  logic                                 last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, pixel_kind, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, pixel_kind, last_pixel,
                  output ready);
endinterface

FILE: hw/rtl/line_rasterizer_top.sv
// ---------------------------------------------------------------------------
// line_rasterizer_top
// Bresenham line rasterizer: start transactions load a line, step
// transactions emit one pixel each while a line is active.
// ---------------------------------------------------------------------------
// Path: a step transaction passes the command register, then the pixel register,
//   before its pixel shows; a blocked pixel can hold it in between.
// Throughput: one transaction per cycle while no held pixel is blocked by the
//   receiver; the step update of the error term and major coordinate sets this rate.
// Reset: synchronous rst clears the command valid flag, line state and pixel
//   valid; no line is active after reset.
`include "assert_macros.svh"

module line_rasterizer_top #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lr_item_if.sink     item,
  lr_pixel_if.source  pixel
);

  logic                           cmd_valid;
  logic                           cmd_op;
  logic signed [COORD_BITS-1:0]   cmd_start_x;
  logic signed [COORD_BITS-1:0]   cmd_start_y;
  logic signed [COORD_BITS-1:0]   cmd_end_x;
  logic signed [COORD_BITS-1:0]   cmd_end_y;
  logic [lr_pkg::COLOR_BITS-1:0]  cmd_color;
  logic [lr_pkg::KIND_BITS-1:0]   cmd_kind;

  lr_pkg::lr_flags_t              flags;
  logic [COORD_BITS-1:0]          major_start;
  logic [COORD_BITS-1:0]          minor_start;
  logic [COORD_BITS-1:0]          major_end;
  logic signed [COORD_BITS+1:0]   err_init;
  logic [COORD_BITS:0]            inc_no_step;
  logic signed [COORD_BITS+1:0]   inc_with_step;
  logic                           take;
  logic                           produce;

  assign item.ready = !cmd_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      cmd_valid <= 1'b1;
    end else if (take) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      cmd_op      <= item.op;
      cmd_start_x <= item.start_x;
      cmd_start_y <= item.start_y;
      cmd_end_x   <= item.end_x;
      cmd_end_y   <= item.end_y;
      cmd_color   <= item.color_index;
      cmd_kind    <= item.coord_kind;
    end
  end

  lr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x       (cmd_start_x),
    .start_y       (cmd_start_y),
    .end_x         (cmd_end_x),
    .end_y         (cmd_end_y),
    .flags         (flags),
    .major_start   (major_start),
    .minor_start   (minor_start),
    .major_end     (major_end),
    .err_init      (err_init),
    .inc_no_step   (inc_no_step),
    .inc_with_step (inc_with_step)
  );

  lr_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd_op           (cmd_op),
    .flags            (flags),
    .major_start      (major_start),
    .minor_start      (minor_start),
    .major_end_in     (major_end),
    .err_init         (err_init),
    .inc_no_step_in   (inc_no_step),
    .inc_with_step_in (inc_with_step),
    .color_in         (cmd_color),
    .kind_in          (cmd_kind),
    .take             (take),
    .produce          (produce),
    .pixel            (pixel)
  );

  `ASSERT_SAME(a_stall_cause, !item.ready, cmd_valid && pixel.valid && !pixel.ready,
    "input stalled without a blocked pixel")
  `ASSERT_NEXT(a_no_pixel, take && !produce,
    pixel.valid == $past(pixel.valid && !pixel.ready), "pixel from a non-producing command")
  `ASSERT_NEXT(a_pixel_loaded, take && produce, pixel.valid,
    "producing step left no pixel")

endmodule

FILE: hw/rtl/lr_setup.sv
// ---------------------------------------------------------------------------
// lr_setup
// Start decode: pick the major axis, step signs, error term and increments.
// ---------------------------------------------------------------------------
module lr_setup #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output lr_pkg::lr_flags_t            flags,
  output logic [COORD_BITS-1:0]        major_start,
  output logic [COORD_BITS-1:0]        minor_start,
  output logic [COORD_BITS-1:0]        major_end,
  output logic signed [COORD_BITS+1:0] err_init,
  output logic [COORD_BITS:0]          inc_no_step,
  output logic signed [COORD_BITS+1:0] inc_with_step
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        adx_w;
  logic [COORD_BITS:0]        ady_w;
  logic [COORD_BITS-1:0]      adx;
  logic [COORD_BITS-1:0]      ady;
  logic [COORD_BITS-1:0]      dmaj;
  logic [COORD_BITS-1:0]      dmin;
  logic                       steep;

  always_comb begin
    dx    = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy    = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    adx_w = dx[COORD_BITS] ? -dx : dx;
    ady_w = dy[COORD_BITS] ? -dy : dy;
    adx   = adx_w[COORD_BITS-1:0];
    ady   = ady_w[COORD_BITS-1:0];
    steep = ady >= adx;

    if (steep) begin
      dmaj        = ady;
      dmin        = adx;
      major_start = start_y;
      minor_start = start_x;
      major_end   = end_y;
    end else begin
      dmaj        = adx;
      dmin        = ady;
      major_start = start_x;
      minor_start = start_y;
      major_end   = end_x;
    end

    flags.steep     = steep;
    flags.major_neg = steep ? dy[COORD_BITS] : dx[COORD_BITS];
    flags.minor_neg = steep ? dx[COORD_BITS] : dy[COORD_BITS];
    flags.nonzero   = dmaj != '0;

    inc_no_step   = {dmin, 1'b0};
    inc_with_step = $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});
    err_init      = $signed({1'b0, dmin, 1'b0}) - $signed({2'b00, dmaj});
  end

endmodule

FILE: hw/rtl/lr_stepper.sv
// ---------------------------------------------------------------------------
// lr_stepper
// Line state, one Bresenham step per step transaction, and the pixel register.
// ---------------------------------------------------------------------------
module lr_stepper #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  logic                            cmd_op,
  input  lr_pkg::lr_flags_t               flags,
  input  logic [COORD_BITS-1:0]           major_start,
  input  logic [COORD_BITS-1:0]           minor_start,
  input  logic [COORD_BITS-1:0]           major_end_in,
  input  logic signed [COORD_BITS+1:0]    err_init,
  input  logic [COORD_BITS:0]             inc_no_step_in,
  input  logic signed [COORD_BITS+1:0]    inc_with_step_in,
  input  logic [lr_pkg::COLOR_BITS-1:0]   color_in,
  input  logic [lr_pkg::KIND_BITS-1:0]    kind_in,
  output logic                            take,
  output logic                            produce,
  lr_pixel_if.source                      pixel
);

  logic                           active;
  logic                           steep_flag;
  logic                           major_dir_neg;
  logic                           minor_dir_neg;
  logic [COORD_BITS-1:0]          major_pos;
  logic [COORD_BITS-1:0]          minor_pos;
  logic [COORD_BITS-1:0]          major_end;
  logic signed [COORD_BITS+1:0]   error_term;
  logic [COORD_BITS:0]            inc_no_step;
  logic signed [COORD_BITS+1:0]   inc_with_step;
  logic [lr_pkg::COLOR_BITS-1:0]  line_color;
  logic [lr_pkg::KIND_BITS-1:0]   line_kind;

  logic                           pix_valid;
  logic                           major_pos_next_last;
  logic [COORD_BITS-1:0]          major_pos_next;
  logic [COORD_BITS-1:0]          minor_pos_next;
  logic signed [COORD_BITS+1:0]   error_term_next;
  logic                           is_start;

  always_comb begin
    is_start = cmd_op == lr_pkg::OP_START;
    produce  = !is_start && active;
    take     = cmd_valid && (!produce || !pix_valid || pixel.ready);

    major_pos_next = major_dir_neg ? major_pos - COORD_BITS'(1) : major_pos + COORD_BITS'(1);
    if (error_term > 0) begin
      error_term_next = error_term + inc_with_step;
      minor_pos_next  = minor_dir_neg ? minor_pos - COORD_BITS'(1)
                                      : minor_pos + COORD_BITS'(1);
    end else begin
      error_term_next = error_term + $signed({1'b0, inc_no_step});
      minor_pos_next  = minor_pos;
    end
    major_pos_next_last = major_pos_next == major_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      steep_flag    <= 1'b0;
      major_dir_neg <= 1'b0;
      minor_dir_neg <= 1'b0;
      major_pos     <= '0;
      minor_pos     <= '0;
      major_end     <= '0;
      error_term    <= '0;
      inc_no_step   <= '0;
      inc_with_step <= '0;
      line_color    <= '0;
      line_kind     <= '0;
    end else if (take) begin
      if (is_start) begin
        active        <= flags.nonzero;
        steep_flag    <= flags.steep;
        major_dir_neg <= flags.major_neg;
        minor_dir_neg <= flags.minor_neg;
        major_pos     <= major_start;
        minor_pos     <= minor_start;
        major_end     <= major_end_in;
        error_term    <= err_init;
        inc_no_step   <= inc_no_step_in;
        inc_with_step <= inc_with_step_in;
        line_color    <= color_in;
        line_kind     <= kind_in;
      end else if (active) begin
        major_pos  <= major_pos_next;
        minor_pos  <= minor_pos_next;
        error_term <= error_term_next;
        if (major_pos_next_last) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Pixel register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (take && produce) begin
      pix_valid <= 1'b1;
    end else if (pixel.ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      pixel.pixel_x     <= steep_flag ? minor_pos : major_pos;
      pixel.pixel_y     <= steep_flag ? major_pos : minor_pos;
      pixel.pixel_color <= line_color;
      pixel.pixel_kind  <= line_kind;
      pixel.last_pixel  <= major_pos_next_last;
    end
  end

  assign pixel.valid = pix_valid;

endmodule

FILE: tb/line_rasterizer_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_rasterizer_top_tb
// Drives start and step transactions into the rasterizer and tracks each
// line's Bresenham walk in a local predictor. Every pixel from the block is
// compared field by field with the oldest predicted pixel. Both channels
// idle at random, with a calm stretch and one long receiver hold-off.
// ---------------------------------------------------------------------------
module line_rasterizer_top_tb;

  localparam int CB          = lr_pkg::COORD_BITS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_ITEMS = 650;

  typedef struct {
    lr_pkg::op_t                   op;
    logic signed [CB-1:0]          x0;
    logic signed [CB-1:0]          y0;
    logic signed [CB-1:0]          x1;
    logic signed [CB-1:0]          y1;
    logic [lr_pkg::COLOR_BITS-1:0] color;
    logic [lr_pkg::KIND_BITS-1:0]  kind;
  } line_cmd_t;

  typedef struct {
    logic signed [CB-1:0]          x;
    logic signed [CB-1:0]          y;
    logic [lr_pkg::COLOR_BITS-1:0] color;
    logic [lr_pkg::KIND_BITS-1:0]  kind;
    logic                          last;
  } pixel_t;

  logic clk;
  logic rst;

  lr_item_if  #(.COORD_BITS(CB)) cmd_if ();
  lr_pixel_if #(.COORD_BITS(CB)) pix_if ();

  line_rasterizer_top #(.COORD_BITS(CB)) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (cmd_if),
    .pixel (pix_if)
  );

  line_cmd_t cmd_q[$];
  pixel_t    pixel_q[$];
  line_cmd_t cur_cmd;

  int items_total;
  int items_sent;
  int errors;
  int stall_cnt;
  int hold_cnt;
  bit held;
  bit calm;

  // predictor state
  bit   line_on;
  bit   steep;
  int   maj;
  int   minr;
  int   maj_end;
  bit   maj_neg;
  bit   min_neg;
  int   err;
  int   inc_flat;
  int   inc_diag;
  logic [lr_pkg::COLOR_BITS-1:0] line_color;
  logic [lr_pkg::KIND_BITS-1:0]  line_kind;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void rasterize_cmd(input line_cmd_t c);
    int     dx;
    int     dy;
    int     dmaj;
    int     dmin;
    pixel_t p;
    if (c.op == lr_pkg::OP_START) begin
      dx = int'(c.x1) - int'(c.x0);
      dy = int'(c.y1) - int'(c.y0);
      steep = magnitude(dy) >= magnitude(dx);
      if (steep) begin
        maj = c.y0; maj_end = c.y1; minr = c.x0; dmaj = dy; dmin = dx;
      end else begin
        maj = c.x0; maj_end = c.x1; minr = c.y0; dmaj = dx; dmin = dy;
      end
      maj_neg = dmaj < 0;
      min_neg = dmin < 0;
      dmaj = magnitude(dmaj);
      dmin = magnitude(dmin);
      inc_flat = 2 * dmin;
      inc_diag = 2 * dmin - 2 * dmaj;
      err = 2 * dmin - dmaj;
      line_color = c.color;
      line_kind = c.kind;
      line_on = dmaj != 0;
    end else if (line_on) begin
      p.x = steep ? minr : maj;
      p.y = steep ? maj : minr;
      p.color = line_color;
      p.kind = line_kind;
      if (err > 0) begin
        err += inc_diag;
        minr += min_neg ? -1 : 1;
      end else begin
        err += inc_flat;
      end
      maj += maj_neg ? -1 : 1;
      p.last = maj == maj_end;
      if (p.last) begin
        line_on = 1'b0;
      end
      pixel_q.push_back(p);
    end
  endfunction

  function automatic void push_start(input int x0, input int y0, input int x1, input int y1,
                                     input int color, input int kind);
    line_cmd_t c;
    c.op = lr_pkg::OP_START;
    c.x0 = x0;
    c.y0 = y0;
    c.x1 = x1;
    c.y1 = y1;
    c.color = color;
    c.kind = kind;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_steps(input int n);
    line_cmd_t c;
    repeat (n) begin
      c.op = lr_pkg::OP_STEP;
      c.x0 = $urandom;
      c.y0 = $urandom;
      c.x1 = $urandom;
      c.y1 = $urandom;
      c.color = $urandom;
      c.kind = $urandom;
      cmd_q.push_back(c);
    end
  endfunction

  function automatic int any_coord();
    case ($urandom_range(3))
      0:       return -32768 + int'($urandom_range(15));
      1:       return 32767 - int'($urandom_range(15));
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic int near_coord(input int base, input int delta);
    if (base + delta > 32767 || base + delta < -32768) begin
      return base - delta;
    end
    return base + delta;
  endfunction

  function automatic void queue_line_sequence();
    int mode;
    int x0;
    int y0;
    int x1;
    int y1;
    int span;
    mode = $urandom_range(99);
    if (mode < 8) begin
      push_steps($urandom_range(1, 3));
    end else if (mode < 14) begin
      push_start(any_coord(), any_coord(), any_coord(), any_coord(), $urandom_range(255),
                 $urandom_range(3));
      push_steps($urandom_range(0, 5));
    end else begin
      x0 = any_coord();
      y0 = any_coord();
      x1 = near_coord(x0, int'($urandom_range(24)) - 12);
      y1 = near_coord(y0, int'($urandom_range(24)) - 12);
      span = magnitude(x1 - x0);
      if (magnitude(y1 - y0) > span) begin
        span = magnitude(y1 - y0);
      end
      push_start(x0, y0, x1, y1, $urandom_range(255), $urandom_range(3));
      if (mode < 30) begin
        push_steps($urandom_range(0, span));
      end else begin
        push_steps(span + int'($urandom_range(2)));
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] pixel mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
      items_sent <= 0;
      calm <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        rasterize_cmd(cur_cmd);
        items_sent <= items_sent + 1;
        calm <= (items_sent >= 150) && (items_sent < 300);
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
          cur_cmd = cmd_q.pop_front();
          cmd_if.valid       <= 1'b1;
          cmd_if.op          <= cur_cmd.op;
          cmd_if.start_x     <= cur_cmd.x0;
          cmd_if.start_y     <= cur_cmd.y0;
          cmd_if.end_x       <= cur_cmd.x1;
          cmd_if.end_y       <= cur_cmd.y1;
          cmd_if.color_index <= cur_cmd.color;
          cmd_if.coord_kind  <= cur_cmd.kind;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pix_if.ready <= 1'b0;
      hold_cnt <= 0;
      held <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected transaction x", int'(pix_if.pixel_x), 0);
        end else begin
          want = pixel_q.pop_front();
          if (pix_if.pixel_x !== want.x) begin
            report_mismatch("pixel_x", int'(pix_if.pixel_x), int'(want.x));
          end
          if (pix_if.pixel_y !== want.y) begin
            report_mismatch("pixel_y", int'(pix_if.pixel_y), int'(want.y));
          end
          if (pix_if.pixel_color !== want.color) begin
            report_mismatch("pixel_color", int'(pix_if.pixel_color), int'(want.color));
          end
          if (pix_if.pixel_kind !== want.kind) begin
            report_mismatch("pixel_kind", int'(pix_if.pixel_kind), int'(want.kind));
          end
          if (pix_if.last_pixel !== want.last) begin
            report_mismatch("last_pixel", int'(pix_if.last_pixel), int'(want.last));
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        pix_if.ready <= 1'b0;
      end else if (!held && items_sent >= 400) begin
        held <= 1'b1;
        hold_cnt <= HOLD_CYCLES;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst) begin
      stall_cnt <= 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.op = lr_pkg::OP_START;
    cmd_if.start_x = '0;
    cmd_if.start_y = '0;
    cmd_if.end_x = '0;
    cmd_if.end_y = '0;
    cmd_if.color_index = '0;
    cmd_if.coord_kind = '0;
    pix_if.ready = 1'b0;
    errors = 0;
    line_on = 1'b0;
    steep = 1'b0;
    maj = 0;
    minr = 0;
    maj_end = 0;
    maj_neg = 1'b0;
    min_neg = 1'b0;
    err = 0;
    inc_flat = 0;
    inc_diag = 0;
    line_color = '0;
    line_kind = '0;

    push_steps(1);
    push_start(4, 4, 4, 4, 8'h3c, 1);
    push_steps(1);
    push_start(-32768, 32767, 32767, -32768, 255, 3);
    push_steps(2);
    push_start(32767, -32768, -32768, 32767, 0, 0);
    push_steps(1);
    push_start(0, 0, 3, 3, 8'ha5, 1);
    push_steps(4);
    push_start(5, -2, 1, 0, 8'h5a, 2);
    push_steps(4);
    push_start(-1, 7, -1, 9, 8'h81, 3);
    push_steps(2);
    push_start(10, 0, 13, 0, 8'h7e, 0);
    push_steps(1);
    push_start(0, 0, -2, -5, 8'hff, 2);
    push_steps(5);
    items_total = cmd_q.size() + RANDOM_ITEMS;
    while (cmd_q.size() < items_total) begin
      queue_line_sequence();
    end
    items_total = cmd_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (items_sent != items_total) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/lr_pkg.sv
hw/rtl/lr_ifs.sv
hw/rtl/lr_setup.sv
hw/rtl/lr_stepper.sv
hw/rtl/line_rasterizer_top.sv
tb/line_rasterizer_top_tb.sv
